// ----- hw/rtl/tcw_pkg.sv -----
// shared types and constants of the text console writer
`default_nettype none

package tcw_pkg;

  // number of consoles, each with its own region of video memory
  localparam int CONSOLES = 4;
  localparam int CIDX_W   = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_WORDS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WORDS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_ATTR    = 2'd3;

  // configuration reset values
  localparam logic [7:0]  RST_LINE_WIDTH   = 8'd80;
  localparam logic [14:0] RST_REGION_WORDS = 15'd4096;
  localparam logic [14:0] RST_SCREEN_WORDS = 15'd2000;
  localparam logic [7:0]  RST_CHAR_ATTR    = 8'd7;

  // operation codes
  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_SELECT = 2'd1;
  localparam logic [1:0] FUNC_UP     = 2'd2;
  localparam logic [1:0] FUNC_DOWN   = 2'd3;

  // character codes
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_BLANK     = 8'h20;
  localparam logic [7:0] ATTR_BLANK   = 8'h00;

  // result kinds
  localparam logic KIND_MEM = 1'b0;
  localparam logic KIND_REG = 1'b1;

  // display controller register indexes
  localparam logic [3:0] REG_START_HI  = 4'hC;
  localparam logic [3:0] REG_START_LO  = 4'hD;
  localparam logic [3:0] REG_CURSOR_HI = 4'hE;
  localparam logic [3:0] REG_CURSOR_LO = 4'hF;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] console_index;
    logic [7:0] character;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [14:0] address;
    logic [7:0]  data;
    logic        last;
  } out_t;

  // origin of a console at the reset region size, wrapped to 15 bits
  function automatic logic [14:0] reset_origin(input int idx);
    logic [31:0] prod;
    prod = 32'(idx) * 32'(RST_REGION_WORDS);
    return prod[14:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/text_console_writer.sv -----
// text console writer: cursor and display start keeping for several consoles
// flow: an accepted item passes lookup (ST_SETUP) and decision (ST_DECIDE), then
//   hands out its 0 to 6 results one per cycle through the output register, unless the output stalls
// a newline that moves the cursor first runs 15 remainder bits, then one cursor update
// items are taken one at a time: a new one is accepted only in idle, after the last is done
// reset: cursors and starts go to index times 4096, config to its defaults
`default_nettype none

module text_console_writer (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  tcw_pkg::in_t                in_data_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output tcw_pkg::out_t                     out_data_o,
  input  wire                               cfg_we_i,
  input  wire  [tcw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [tcw_pkg::CFG_DAT_W-1:0]     cfg_data_i
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP  = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_NLUPD  = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  // result slots: two memory bytes, cursor pair, start pair
  localparam logic [2:0] IDX_MEM   = 3'd0;
  localparam logic [2:0] IDX_ATTR  = 3'd1;
  localparam logic [2:0] IDX_CURHI = 3'd2;
  localparam logic [2:0] IDX_CURLO = 3'd3;
  localparam logic [2:0] IDX_STHI  = 3'd4;
  localparam logic [2:0] IDX_LAST  = 3'd5;

  localparam logic [3:0] DIV_STEPS = 4'd15;

  logic [2:0]  state_q;
  logic [7:0]  line_width_q;
  logic [14:0] region_q;
  logic [14:0] screen_q;
  logic [7:0]  attr_q;
  logic [14:0] cursor_q [tcw_pkg::CONSOLES];
  logic [14:0] start_q  [tcw_pkg::CONSOLES];
  logic [2:0]  active_q;

  logic [1:0]  func_q;
  logic [2:0]  cons_q;
  logic [7:0]  ch_q;
  logic [17:0] origin_q;
  logic [14:0] cur_q;
  logic [14:0] st_q;
  logic [14:0] off_q;
  logic [14:0] dvd_q;
  logic [7:0]  rem_q;
  logic [3:0]  cnt_q;
  logic [14:0] p_q;
  logic [7:0]  mdata_q;
  logic [7:0]  adata_q;
  logic [2:0]  idx_q;
  logic        out_valid_q;
  tcw_pkg::out_t out_q;

  logic [tcw_pkg::CIDX_W-1:0] ci;
  logic [7:0]  lw;
  logic [17:0] limit;
  logic        nl_ok, adv_ok, bs_ok, up_ok, dn_ok;
  logic [14:0] off_new;
  logic [8:0]  trial;
  logic        trial_ge;
  logic [8:0]  trial_sub;
  logic [18:0] nl_sum;
  logic        emit_go;
  logic        in_xfer;
  logic        cons_ok;
  tcw_pkg::out_t emit_item;

  assign ci      = cons_q[tcw_pkg::CIDX_W-1:0];
  assign lw      = (line_width_q == 8'd0) ? 8'd1 : line_width_q;
  assign limit   = origin_q + {3'b0, region_q};
  assign nl_ok   = ({4'b0, cur_q} + {11'b0, lw}) < {1'b0, limit};
  assign adv_ok  = ({4'b0, cur_q} + 19'd1) < {1'b0, limit};
  assign bs_ok   = {3'b0, cur_q} > origin_q;
  assign up_ok   = {3'b0, st_q} > origin_q;
  assign dn_ok   = ({4'b0, st_q} + {3'b0, screen_q, 1'b0}) < {1'b0, limit};
  assign off_new = bs_ok ? (cur_q - origin_q[14:0]) : 15'd0;

  // subtractor of the remainder loop: one remainder bit per cycle
  assign trial     = {rem_q, dvd_q[14]};
  assign trial_ge  = trial >= {1'b0, lw};
  assign trial_sub = trial - {1'b0, lw};

  // next line start: origin + offset - offset mod width + width
  assign nl_sum = {1'b0, origin_q} + {4'b0, off_q} + {11'b0, lw} - {11'b0, rem_q};

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign cons_ok    = {1'b0, in_data_i.console_index} < 4'(tcw_pkg::CONSOLES);
  assign emit_go    = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    emit_item      = '0;
    emit_item.last = (idx_q == IDX_LAST);
    case (idx_q)
      IDX_MEM: begin
        emit_item.kind    = tcw_pkg::KIND_MEM;
        emit_item.address = {p_q[13:0], 1'b0};
        emit_item.data    = mdata_q;
      end
      IDX_ATTR: begin
        emit_item.kind    = tcw_pkg::KIND_MEM;
        emit_item.address = {p_q[13:0], 1'b1};
        emit_item.data    = adata_q;
      end
      IDX_CURHI: begin
        emit_item.kind    = tcw_pkg::KIND_REG;
        emit_item.address = 15'(tcw_pkg::REG_CURSOR_HI);
        emit_item.data    = {1'b0, cursor_q[ci][14:8]};
      end
      IDX_CURLO: begin
        emit_item.kind    = tcw_pkg::KIND_REG;
        emit_item.address = 15'(tcw_pkg::REG_CURSOR_LO);
        emit_item.data    = cursor_q[ci][7:0];
      end
      IDX_STHI: begin
        emit_item.kind    = tcw_pkg::KIND_REG;
        emit_item.address = 15'(tcw_pkg::REG_START_HI);
        emit_item.data    = {1'b0, start_q[ci][14:8]};
      end
      IDX_LAST: begin
        emit_item.kind    = tcw_pkg::KIND_REG;
        emit_item.address = 15'(tcw_pkg::REG_START_LO);
        emit_item.data    = start_q[ci][7:0];
      end
      default: begin
        emit_item = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      line_width_q <= tcw_pkg::RST_LINE_WIDTH;
      region_q     <= tcw_pkg::RST_REGION_WORDS;
      screen_q     <= tcw_pkg::RST_SCREEN_WORDS;
      attr_q       <= tcw_pkg::RST_CHAR_ATTR;
      for (int i = 0; i < tcw_pkg::CONSOLES; i++) begin
        cursor_q[i] <= tcw_pkg::reset_origin(i);
        start_q[i]  <= tcw_pkg::reset_origin(i);
      end
      active_q    <= 3'd0;
      func_q      <= '0;
      cons_q      <= '0;
      ch_q        <= '0;
      origin_q    <= '0;
      cur_q       <= '0;
      st_q        <= '0;
      off_q       <= '0;
      dvd_q       <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      p_q         <= '0;
      mdata_q     <= '0;
      adata_q     <= '0;
      idx_q       <= IDX_MEM;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          tcw_pkg::CFG_LINE_WIDTH:   line_width_q <= cfg_data_i[7:0];
          tcw_pkg::CFG_REGION_WORDS: region_q     <= cfg_data_i;
          tcw_pkg::CFG_SCREEN_WORDS: screen_q     <= cfg_data_i;
          tcw_pkg::CFG_CHAR_ATTR:    attr_q       <= cfg_data_i[7:0];
          default: begin
          end
        endcase
      end

      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_xfer && cons_ok) begin
            func_q  <= in_data_i.func;
            cons_q  <= in_data_i.console_index;
            ch_q    <= in_data_i.character;
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          origin_q <= 18'(cons_q) * 18'(region_q);
          cur_q    <= cursor_q[ci];
          st_q     <= start_q[ci];
          state_q  <= ST_DECIDE;
        end
        ST_DECIDE: begin
          case (func_q)
            tcw_pkg::FUNC_WRITE: begin
              if (ch_q == tcw_pkg::CH_NEWLINE) begin
                if (nl_ok) begin
                  off_q   <= off_new;
                  dvd_q   <= off_new;
                  rem_q   <= 8'd0;
                  cnt_q   <= DIV_STEPS;
                  state_q <= ST_DIV;
                end else begin
                  idx_q   <= IDX_CURHI;
                  state_q <= ST_EMIT;
                end
              end else if (ch_q == tcw_pkg::CH_BACKSPACE) begin
                state_q <= ST_EMIT;
                if (bs_ok) begin
                  p_q          <= cur_q - 15'd1;
                  cursor_q[ci] <= cur_q - 15'd1;
                  mdata_q      <= tcw_pkg::CH_BLANK;
                  adata_q      <= tcw_pkg::ATTR_BLANK;
                  idx_q        <= IDX_MEM;
                end else begin
                  idx_q <= IDX_CURHI;
                end
              end else begin
                state_q <= ST_EMIT;
                if (adv_ok) begin
                  p_q          <= cur_q;
                  cursor_q[ci] <= cur_q + 15'd1;
                  mdata_q      <= ch_q;
                  adata_q      <= attr_q;
                  idx_q        <= IDX_MEM;
                end else begin
                  idx_q <= IDX_CURHI;
                end
              end
            end
            tcw_pkg::FUNC_SELECT: begin
              active_q <= cons_q;
              idx_q    <= IDX_CURHI;
              state_q  <= ST_EMIT;
            end
            tcw_pkg::FUNC_UP: begin
              idx_q <= IDX_STHI;
              if (up_ok) begin
                start_q[ci] <= st_q - screen_q;
                state_q     <= ST_EMIT;
              end else begin
                state_q <= ST_IDLE;
              end
            end
            tcw_pkg::FUNC_DOWN: begin
              idx_q <= IDX_STHI;
              if (dn_ok) begin
                start_q[ci] <= st_q + screen_q;
                state_q     <= ST_EMIT;
              end else begin
                state_q <= ST_IDLE;
              end
            end
            default: begin
              state_q <= ST_IDLE;
            end
          endcase
        end
        ST_DIV: begin
          rem_q <= trial_ge ? trial_sub[7:0] : trial[7:0];
          dvd_q <= {dvd_q[13:0], 1'b0};
          cnt_q <= cnt_q - 4'd1;
          if (cnt_q == 4'd1) begin
            state_q <= ST_NLUPD;
          end
        end
        ST_NLUPD: begin
          cursor_q[ci] <= nl_sum[14:0];
          idx_q        <= IDX_CURHI;
          state_q      <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_q <= emit_item;
            idx_q <= idx_q + 3'd1;
            if (idx_q == IDX_LAST) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a console select never records an index outside the console range
  a_active_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, active_q} < 4'(tcw_pkg::CONSOLES))
    else $error("active console out of range");

  // an accepted item either starts the lookup or is dropped for a bad index
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_SETUP || state_q == ST_IDLE))
    else $error("unexpected state after input transfer");

  // the result marked last ends the item
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_go && idx_q == IDX_LAST) |=> (state_q == ST_IDLE && out_q.last))
    else $error("last result did not end the item");

  // the remainder loop never runs past its step count
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q != 4'd0 && cnt_q <= DIV_STEPS))
    else $error("remainder step count out of range");

endmodule

`default_nettype wire
